### src/ppu_pkg.sv
// ----------------------------------------------------------------------------
// Pinhole projection package
// Shared constants, register indexes, sideband type and a saturating add helper.
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int DIV_STEPS      = 33;
    localparam int LATENCY        = 10 + DIV_STEPS;

    localparam logic signed [63:0] DEPTH_MIN   = 64'sd6554;
    localparam logic signed [63:0] CAM_MAX     = 64'sd2147483647;
    localparam logic signed [63:0] CAM_MIN     = -64'sd2147483648;
    localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;
    localparam logic [31:0]        POS_SAT     = 32'h7fff_ffff;
    localparam logic [31:0]        NEG_SAT     = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_EXT_ROW0,
        REG_EXT_ROW1,
        REG_EXT_ROW2,
        REG_INT_ROW0,
        REG_INT_ROW1,
        REG_INT_ROW2,
        REG_EXT_FRAC,
        REG_INT_FRAC
    } reg_index_t;

    typedef struct packed {
        logic       behind;
        logic       cam_ovf;
        logic       zero_div;
        logic [1:0] neg;
        logic [1:0] big;
        logic [1:0] num_neg;
        logic [1:0] num_zero;
    } side_t;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            r = s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

### src/pinhole_point_projection_unit.sv
// ----------------------------------------------------------------------------
// Pinhole point projection unit
// Projects Q16.16 world points through extrinsic and intrinsic matrices.
// ----------------------------------------------------------------------------
// A point word is taken at each rising edge with start high and busy low.
// Busy is always low, so one point can enter in every cycle.
// Each point gives one result word, shown for one cycle with done high.
// Each point passes stages of multiply, saturating add, shift, clamp and
// divider setup, then the 33-stage pipelined divider, which produces one
// quotient bit per stage, and an output register.
// Throughput is one point per cycle.
// Matrix rows and the extrinsic fraction width come via wr_en, wr_index and
// wr_data; the user writes only while no point is in flight; not enforced.
// Reset clears all valid bits and loads the identity camera setup.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module pinhole_point_projection_unit
    import ppu_pkg::*;
#(
    parameter int COEF_WIDTH = COEF_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               done,
    output logic signed [31:0] pixel_u,
    output logic signed [31:0] pixel_v,
    output logic               behind,
    output logic               overflow,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [63:0]        wr_data
);

    localparam int EXT_SPAN = 64 + 4 * COEF_WIDTH;
    localparam int INT_SPAN = 48 + 3 * COEF_WIDTH;
    localparam int PW       = COEF_WIDTH + 32;

    logic [63:0] ext_row_reg [3];
    logic [47:0] int_row_reg [3];
    logic [3:0]  ext_frac_reg;

    function automatic logic signed [COEF_WIDTH-1:0] ext_coef(input logic [63:0] r,
                                                             input int j);
        logic [EXT_SPAN-1:0] w;
        w = {{(4 * COEF_WIDTH){1'b0}}, r};
        return w[j*COEF_WIDTH +: COEF_WIDTH];
    endfunction

    function automatic logic signed [COEF_WIDTH-1:0] int_coef(input logic [47:0] r,
                                                             input int j);
        logic [INT_SPAN-1:0] w;
        w = {{(3 * COEF_WIDTH){1'b0}}, r};
        return w[j*COEF_WIDTH +: COEF_WIDTH];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_row_reg[0] <= 64'd4096;
            ext_row_reg[1] <= 64'd268435456;
            ext_row_reg[2] <= 64'd17592186044416;
            int_row_reg[0] <= 48'd16;
            int_row_reg[1] <= 48'd1048576;
            int_row_reg[2] <= 48'd68719476736;
            ext_frac_reg   <= 4'd12;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_EXT_ROW0: ext_row_reg[0] <= wr_data;
                REG_EXT_ROW1: ext_row_reg[1] <= wr_data;
                REG_EXT_ROW2: ext_row_reg[2] <= wr_data;
                REG_INT_ROW0: int_row_reg[0] <= wr_data[47:0];
                REG_INT_ROW1: int_row_reg[1] <= wr_data[47:0];
                REG_INT_ROW2: int_row_reg[2] <= wr_data[47:0];
                REG_EXT_FRAC: ext_frac_reg   <= wr_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits of all stages.
    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic                 s6_vld_reg, s7_vld_reg, s8_vld_reg, out_vld_reg;
    logic                 dv_vld_reg [DIV_STEPS+1];

    logic                 accept;
    assign accept = start && !busy;

    // Stage 1: extrinsic products.
    logic signed [31:0]   pnt [3];
    logic signed [PW-1:0] ep_full [3][3];
    logic signed [63:0]   s1_p_next [3][4];
    logic signed [63:0]   s1_p_reg  [3][4];

    assign pnt[0] = point_x;
    assign pnt[1] = point_y;
    assign pnt[2] = point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                ep_full[i][j]   = ext_coef(ext_row_reg[i], j) * pnt[j];
                s1_p_next[i][j] = 64'(ep_full[i][j]);
            end
            s1_p_next[i][3] = 64'(ext_coef(ext_row_reg[i], 3)) <<< 16;
        end
    end

    // Stages 2 to 4: saturating accumulation in model order.
    logic signed [63:0]   s2_acc_reg [3], s2_p2_reg [3], s2_p3_reg [3];
    logic signed [63:0]   s3_acc_reg [3], s3_p3_reg [3];
    logic signed [63:0]   s4_acc_reg [3];

    // Stage 5: shift, depth test and clamp.
    logic signed [63:0]   cam_shift [3];
    logic signed [31:0]   s5_c_next [3];
    logic                 s5_behind_next, s5_ovf_next;
    logic signed [31:0]   s5_c_reg [3];
    logic                 s5_behind_reg, s5_ovf_reg;

    always_comb
    begin
        s5_ovf_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cam_shift[i] = s4_acc_reg[i] >>> ext_frac_reg;
            if (cam_shift[i] > CAM_MAX)
            begin
                s5_c_next[i] = POS_SAT;
                s5_ovf_next  = 1'b1;
            end
            else if (cam_shift[i] < CAM_MIN)
            begin
                s5_c_next[i] = NEG_SAT;
                s5_ovf_next  = 1'b1;
            end
            else
            begin
                s5_c_next[i] = cam_shift[i][31:0];
            end
        end
        s5_behind_next = cam_shift[2] < DEPTH_MIN;
    end

    // Stage 6: intrinsic products.
    logic signed [PW-1:0] kp_full [3][3];
    logic signed [63:0]   s6_p_next [3][3];
    logic signed [63:0]   s6_p_reg  [3][3];
    logic                 s6_behind_reg, s6_ovf_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                kp_full[i][j]   = int_coef(int_row_reg[i], j) * s5_c_reg[j];
                s6_p_next[i][j] = 64'(kp_full[i][j]);
            end
        end
    end

    // Stages 7 and 8: intrinsic sums.
    logic signed [63:0]   s7_acc_reg [3], s7_p2_reg [3];
    logic                 s7_behind_reg, s7_ovf_reg;
    logic signed [63:0]   s8_r_reg [3];
    logic                 s8_behind_reg, s8_ovf_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                s1_p_reg[i][j] <= s1_p_next[i][j];
            end
            s2_acc_reg[i] <= sat_add64(s1_p_reg[i][0], s1_p_reg[i][1]);
            s2_p2_reg[i]  <= s1_p_reg[i][2];
            s2_p3_reg[i]  <= s1_p_reg[i][3];
            s3_acc_reg[i] <= sat_add64(s2_acc_reg[i], s2_p2_reg[i]);
            s3_p3_reg[i]  <= s2_p3_reg[i];
            s4_acc_reg[i] <= sat_add64(s3_acc_reg[i], s3_p3_reg[i]);
            s5_c_reg[i]   <= s5_c_next[i];
            for (int j = 0; j < 3; j++)
            begin
                s6_p_reg[i][j] <= s6_p_next[i][j];
            end
            s7_acc_reg[i] <= sat_add64(s6_p_reg[i][0], s6_p_reg[i][1]);
            s7_p2_reg[i]  <= s6_p_reg[i][2];
            s8_r_reg[i]   <= sat_add64(s7_acc_reg[i], s7_p2_reg[i]);
        end
        s5_behind_reg <= s5_behind_next;
        s5_ovf_reg    <= s5_ovf_next;
        s6_behind_reg <= s5_behind_reg;
        s6_ovf_reg    <= s5_ovf_reg;
        s7_behind_reg <= s6_behind_reg;
        s7_ovf_reg    <= s6_ovf_reg;
        s8_behind_reg <= s7_behind_reg;
        s8_ovf_reg    <= s7_ovf_reg;
    end

    // Divider: stage 0 holds the setup, each later stage one quotient bit.
    logic [63:0]          dv_rem_reg [DIV_STEPS+1][2];
    logic [DIV_STEPS-1:0] dv_q_reg   [DIV_STEPS+1][2];
    logic [DIV_STEPS-1:0] dv_nsh_reg [DIV_STEPS+1][2];
    logic [63:0]          dv_ud_reg  [DIV_STEPS+1];
    side_t                dv_side_reg [DIV_STEPS+1];

    logic [63:0]          setup_ud;
    logic [63:0]          setup_un [2];
    side_t                setup_side;

    always_comb
    begin
        setup_ud = s8_r_reg[2][63] ? 64'(-s8_r_reg[2]) : 64'(s8_r_reg[2]);
        setup_side.behind   = s8_behind_reg;
        setup_side.cam_ovf  = s8_ovf_reg;
        setup_side.zero_div = setup_ud == 64'd0;
        for (int l = 0; l < 2; l++)
        begin
            setup_un[l] = s8_r_reg[l][63] ? 64'(-s8_r_reg[l]) : 64'(s8_r_reg[l]);
            setup_side.neg[l]      = s8_r_reg[l][63] ^ s8_r_reg[2][63];
            setup_side.big[l]      = (setup_un[l] >> 17) >= setup_ud;
            setup_side.num_neg[l]  = s8_r_reg[l][63];
            setup_side.num_zero[l] = s8_r_reg[l] == 64'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        dv_ud_reg[0]   <= setup_ud;
        dv_side_reg[0] <= setup_side;
        for (int l = 0; l < 2; l++)
        begin
            dv_rem_reg[0][l] <= {17'd0, setup_un[l][63:17]};
            dv_q_reg[0][l]   <= '0;
            dv_nsh_reg[0][l] <= {setup_un[l][16:0], 16'd0};
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        logic [64:0] trial [2];
        logic        fits  [2];

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                trial[l] = {dv_rem_reg[s][l], dv_nsh_reg[s][l][DIV_STEPS-1]};
                fits[l]  = trial[l] >= {1'b0, dv_ud_reg[s]};
            end
        end

        always_ff @(posedge clk)
        begin
            dv_ud_reg[s+1]   <= dv_ud_reg[s];
            dv_side_reg[s+1] <= dv_side_reg[s];
            for (int l = 0; l < 2; l++)
            begin
                dv_rem_reg[s+1][l] <= fits[l] ? 64'(trial[l] - {1'b0, dv_ud_reg[s]})
                                              : trial[l][63:0];
                dv_q_reg[s+1][l]   <= {dv_q_reg[s][l][DIV_STEPS-2:0], fits[l]};
                dv_nsh_reg[s+1][l] <= dv_nsh_reg[s][l] << 1;
            end
        end
    end

    // Output selection.
    side_t                fin_side;
    logic [DIV_STEPS-1:0] lim   [2];
    logic [DIV_STEPS-1:0] qsat  [2];
    logic [31:0]          lane  [2];
    logic                 lane_ovf [2];
    logic signed [31:0]   pixel_u_next, pixel_v_next;
    logic                 behind_next, overflow_next;
    logic signed [31:0]   pixel_u_reg, pixel_v_reg;
    logic                 behind_reg, overflow_reg;

    always_comb
    begin
        fin_side = dv_side_reg[DIV_STEPS];
        for (int l = 0; l < 2; l++)
        begin
            lim[l] = fin_side.neg[l] ? DIV_STEPS'(33'h0_8000_0000)
                                     : DIV_STEPS'(33'h0_7fff_ffff);
            qsat[l]     = dv_q_reg[DIV_STEPS][l];
            lane_ovf[l] = 1'b0;
            if (fin_side.big[l] || (dv_q_reg[DIV_STEPS][l] > lim[l]))
            begin
                qsat[l]     = lim[l];
                lane_ovf[l] = 1'b1;
            end
            lane[l] = fin_side.neg[l] ? 32'(-qsat[l][31:0]) : qsat[l][31:0];
            if (fin_side.zero_div)
            begin
                lane_ovf[l] = 1'b1;
                if (fin_side.num_neg[l])
                begin
                    lane[l] = NEG_SAT;
                end
                else if (fin_side.num_zero[l])
                begin
                    lane[l] = 32'd0;
                end
                else
                begin
                    lane[l] = POS_SAT;
                end
            end
        end
        if (fin_side.behind)
        begin
            pixel_u_next  = NEG_ONE_Q16;
            pixel_v_next  = NEG_ONE_Q16;
            behind_next   = 1'b1;
            overflow_next = 1'b0;
        end
        else
        begin
            pixel_u_next  = lane[0];
            pixel_v_next  = lane[1];
            behind_next   = 1'b0;
            overflow_next = fin_side.cam_ovf || lane_ovf[0] || lane_ovf[1];
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_u_reg  <= pixel_u_next;
        pixel_v_reg  <= pixel_v_next;
        behind_reg   <= behind_next;
        overflow_reg <= overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                dv_vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            s1_vld_reg    <= accept;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            s5_vld_reg    <= s4_vld_reg;
            s6_vld_reg    <= s5_vld_reg;
            s7_vld_reg    <= s6_vld_reg;
            s8_vld_reg    <= s7_vld_reg;
            dv_vld_reg[0] <= s8_vld_reg;
            for (int s = 0; s < DIV_STEPS; s++)
            begin
                dv_vld_reg[s+1] <= dv_vld_reg[s];
            end
            out_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    assign done     = out_vld_reg;
    assign pixel_u  = pixel_u_reg;
    assign pixel_v  = pixel_v_reg;
    assign behind   = behind_reg;
    assign overflow = overflow_reg;

endmodule

### src/ppu_checker.sv
// ----------------------------------------------------------------------------
// Pinhole projection checker
// Port-level timing and result checks, bound to the top level.
// ----------------------------------------------------------------------------
module ppu_checker
    import ppu_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [31:0] pixel_u,
    input logic signed [31:0] pixel_v,
    input logic               behind,
    input logic               overflow
);

    // Every accepted word comes out after the fixed latency.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("result word missing after accept");

    // No result word appears without an accepted input word.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result word without accepted input");

    // A point behind the camera reports minus one in both coordinates.
    a_behind_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && behind) |->
            (pixel_u == NEG_ONE_Q16) && (pixel_v == NEG_ONE_Q16) && !overflow)
        else $error("behind word carries wrong payload");

endmodule

bind pinhole_point_projection_unit ppu_checker u_ppu_checker (.*);
